>>> rtl/tpv_pkg.sv
// ----------------------------------------------------------------------------
// tpv_pkg
// Shared widths, codes and defaults of the triangle plane unit.
// ----------------------------------------------------------------------------
package tpv_pkg;

	// Default store depth and kept coordinate width.
	localparam int VERTEX_DEPTH_DEF = 4096;
	localparam int COORD_BITS_DEF   = 32;

	// Fixed field widths of the channels.
	localparam int SLOT_W  = 12;
	localparam int COORD_W = 32;
	localparam int NORM_W  = 32;
	localparam int DIST_W  = 32;

	// Item kinds.
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_COMPUTE = 1'b1;

endpackage

>>> rtl/tpv_item_if.sv
// ----------------------------------------------------------------------------
// tpv_item_if
// Input channel: vertex loads and triangle compute requests.
// ----------------------------------------------------------------------------
interface tpv_item_if;
	import tpv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [SLOT_W-1:0]          vertex_slot;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic signed [COORD_W-1:0]  coord_z;
	logic [SLOT_W-1:0]          corner_a;
	logic [SLOT_W-1:0]          corner_b;
	logic [SLOT_W-1:0]          corner_c;

	modport source (output valid, mode, vertex_slot, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, mode, vertex_slot, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

>>> rtl/tpv_result_if.sv
// ----------------------------------------------------------------------------
// tpv_result_if
// Output channel: unit normal, plane distance and degenerate flag.
// ----------------------------------------------------------------------------
interface tpv_result_if;
	import tpv_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [NORM_W-1:0]  normal_x;
	logic signed [NORM_W-1:0]  normal_y;
	logic signed [NORM_W-1:0]  normal_z;
	logic signed [DIST_W-1:0]  plane_distance;
	logic                      degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, plane_distance,
		degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, plane_distance,
		degenerate, output ready);
endinterface

>>> rtl/tpv_ram.sv
// ----------------------------------------------------------------------------
// tpv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpv_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/tpv_div.sv
// ----------------------------------------------------------------------------
// tpv_div
// Restoring divider, one quotient bit a cycle, for quotients below 2^32.
// ----------------------------------------------------------------------------
module tpv_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic        fits;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, lo_q[31]};
		fits  = trial >= {1'b0, den_q};
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[63:32];
			lo_q  <= num[31:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			lo_q  <= {lo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = lo_q;
endmodule

>>> rtl/tpv_sqrt.sv
// ----------------------------------------------------------------------------
// tpv_sqrt
// Integer square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module tpv_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Digit-by-digit root.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule

>>> rtl/triangle_plane_from_vertices.sv
// ----------------------------------------------------------------------------
// triangle_plane_from_vertices
// Vertex store plus plane unit: unit normal and plane distance of a triangle.
//
//  channel  | dir | words
//  ---------+-----+--------------------------------------------------------
//  item     | in  | load a vertex (mode 0) or compute a triangle (mode 1)
//  result   | out | normal x/y/z Q2.30, distance Q16.16, degenerate flag
//
// A load word is written to the store as it is taken; the unit stays idle.
// After a compute word the next word is taken once the result is loaded:
// three store reads, six cross products, three squares and three dot-product
// terms on the shared multiplier, the normalising shifts, a square root, three
// divisions and a divide by three by reciprocal multiplication lie between.
// A saturating distance skips the divide by three; a degenerate triangle goes
// from the cross product straight to the result. Words are taken only while
// no compute is in flight. The result register lets the next word in while a
// result waits; a finished compute stalls until that register is free.
// Reset clears control only; the store holds nothing until written.
// ----------------------------------------------------------------------------
module triangle_plane_from_vertices #(
	parameter int VERTEX_DEPTH = tpv_pkg::VERTEX_DEPTH_DEF,
	parameter int COORD_BITS   = tpv_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	tpv_item_if.sink     item,
	tpv_result_if.source result
);
	import tpv_pkg::*;

	localparam int CW  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int AW  = $clog2(VERTEX_DEPTH);
	localparam int DW  = CW + 1;
	localparam int SW  = CW + 2;
	localparam int XW  = 2 * DW + 1;
	localparam int MW  = (SW > 32) ? SW : 32;
	localparam int PW  = 2 * MW;
	localparam int DAW = PW + 2;

	// Reciprocal of three, rounded up, scaled by 2^35.
	localparam logic [33:0] RECIP3 = 34'h2_AAAA_AAAB;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD1  = 4'd1;
	localparam logic [3:0] S_RD2  = 4'd2;
	localparam logic [3:0] S_RD3  = 4'd3;
	localparam logic [3:0] S_DIFF = 4'd4;
	localparam logic [3:0] S_XMUL = 4'd5;
	localparam logic [3:0] S_MAG  = 4'd6;
	localparam logic [3:0] S_NORM = 4'd7;
	localparam logic [3:0] S_SQ   = 4'd8;
	localparam logic [3:0] S_SQRT = 4'd9;
	localparam logic [3:0] S_NDIV = 4'd10;
	localparam logic [3:0] S_DOT  = 4'd11;
	localparam logic [3:0] S_DCHK = 4'd12;
	localparam logic [3:0] S_DDIV = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	logic [3:0] state_q;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;

	logic              accept;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [3*CW-1:0]   wdata;
	logic [3*CW-1:0]   rdata;

	logic [SLOT_W-1:0] slot_b_q;
	logic [SLOT_W-1:0] slot_c_q;
	logic              ok_a_q, ok_b_q, ok_c_q;

	logic signed [CW-1:0]  va_q [3];
	logic signed [CW-1:0]  vb_q [3];
	logic signed [CW-1:0]  vc_q [3];
	logic signed [DW-1:0]  ve_q [3];
	logic signed [DW-1:0]  vw_q [3];
	logic signed [SW-1:0]  sum_q [3];
	logic signed [XW-1:0]  cr_q [3];
	logic [XW-1:0]         mag_q [3];
	logic                  neg_q [3];
	logic [63:0]           sumsq_q;
	logic [31:0]           m_q;
	logic signed [NORM_W-1:0] nrm_q [3];
	logic signed [DAW-1:0] dot_q;
	logic signed [DIST_W-1:0] dist_q;
	logic                  degen_q;
	logic [33:0]           dm_q;
	logic [67:0]           q3_q;
	logic [31:0]           quo3;

	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [PW-1:0]  prod_q;

	logic        div_start_q, sqrt_start_q;
	logic        div_done, sqrt_done;
	logic [63:0] div_num;
	logic [31:0] div_den;
	logic [31:0] div_quo;
	logic [31:0] sqrt_root;

	logic [XW-1:0]  mag_or;
	logic [DAW-1:0] dot_abs;
	logic [DAW-1:0] dm;
	logic           dneg;
	logic           dsat;

	logic                     out_valid_q;
	logic signed [NORM_W-1:0] out_nx_q, out_ny_q, out_nz_q;
	logic signed [DIST_W-1:0] out_dist_q;
	logic                     out_degen_q;
	logic                     out_load;

	// Slot to store address, zero-extended when the store is deeper.
	function automatic logic [AW-1:0] slot_addr(input logic [SLOT_W-1:0] s);
		logic [AW+SLOT_W-1:0] ext;
		ext = {{AW{1'b0}}, s};
		return ext[AW-1:0];
	endfunction

	function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
		return 32'(s) < 32'(VERTEX_DEPTH);
	endfunction

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	// Store ports: loads write, computes read the three corners in turn.
	assign we    = accept && (item.mode == MODE_LOAD) && slot_ok(item.vertex_slot);
	assign waddr = slot_addr(item.vertex_slot);
	assign wdata = {item.coord_z[CW-1:0], item.coord_y[CW-1:0], item.coord_x[CW-1:0]};

	always_comb begin
		case (state_q)
			S_RD1:   raddr = slot_addr(slot_b_q);
			S_RD2:   raddr = slot_addr(slot_c_q);
			default: raddr = slot_addr(item.corner_a);
		endcase
	end

	tpv_ram #(.WIDTH(3 * CW), .DEPTH(VERTEX_DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_XMUL: begin
				case (cnt_q)
					3'd0: begin mul_a = MW'(ve_q[1]); mul_b = MW'(vw_q[2]); end
					3'd1: begin mul_a = MW'(ve_q[2]); mul_b = MW'(vw_q[1]); end
					3'd2: begin mul_a = MW'(ve_q[2]); mul_b = MW'(vw_q[0]); end
					3'd3: begin mul_a = MW'(ve_q[0]); mul_b = MW'(vw_q[2]); end
					3'd4: begin mul_a = MW'(ve_q[0]); mul_b = MW'(vw_q[1]); end
					3'd5: begin mul_a = MW'(ve_q[1]); mul_b = MW'(vw_q[0]); end
					default: ;
				endcase
			end
			S_SQ: begin
				if (cnt_q < 3'd3) begin
					mul_a = MW'($signed({1'b0, mag_q[cnt_q[1:0]][30:0]}));
					mul_b = mul_a;
				end
			end
			S_DOT: begin
				if (cnt_q < 3'd3) begin
					mul_a = MW'(nrm_q[cnt_q[1:0]]);
					mul_b = MW'(sum_q[cnt_q[1:0]]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Normalisation, distance magnitude and saturation test.
	always_comb begin
		mag_or  = mag_q[0] | mag_q[1] | mag_q[2];
		dneg    = dot_q[DAW-1];
		dot_abs = dneg ? DAW'(-dot_q) : DAW'(dot_q);
		dm      = (dot_abs + DAW'(64'h6000_0000)) >> 30;
		dsat    = dm >= DAW'(64'h3_0000_0000);
	end

	// The divider forms the normal components.
	always_comb begin
		div_num = (64'(mag_q[idx_q][30:0]) << 30) + 64'(m_q >> 1);
		div_den = m_q;
	end

	// Quotient of the distance by three, taken from the reciprocal product.
	assign quo3 = q3_q[66:35];

	tpv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	tpv_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (sumsq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign out_load = (state_q == S_FIN) && (!out_valid_q || result.ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
		end else begin
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.mode == MODE_COMPUTE) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_DIFF;
				S_DIFF: begin
					cnt_q   <= '0;
					state_q <= S_XMUL;
				end
				S_XMUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					if (cr_q[0] == '0 && cr_q[1] == '0 && cr_q[2] == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!(|mag_or[XW-1:31]) && mag_or[30]) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						sqrt_start_q <= 1'b1;
						state_q      <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						idx_q       <= '0;
						div_start_q <= 1'b1;
						state_q     <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (div_done) begin
						if (idx_q == 2'd2) begin
							cnt_q   <= '0;
							state_q <= S_DOT;
						end else begin
							idx_q       <= idx_q + 2'd1;
							div_start_q <= 1'b1;
						end
					end
				end
				S_DOT: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					if (dsat) begin
						state_q <= S_FIN;
					end else begin
						cnt_q   <= '0;
						state_q <= S_DDIV;
					end
				end
				S_DDIV: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				slot_b_q <= item.corner_b;
				slot_c_q <= item.corner_c;
				ok_a_q   <= slot_ok(item.corner_a);
				ok_b_q   <= slot_ok(item.corner_b);
				ok_c_q   <= slot_ok(item.corner_c);
			end
			S_RD1: begin
				for (int i = 0; i < 3; i++) begin
					va_q[i] <= ok_a_q ? $signed(rdata[i*CW +: CW]) : '0;
				end
			end
			S_RD2: begin
				for (int i = 0; i < 3; i++) begin
					vb_q[i] <= ok_b_q ? $signed(rdata[i*CW +: CW]) : '0;
				end
			end
			S_RD3: begin
				for (int i = 0; i < 3; i++) begin
					vc_q[i] <= ok_c_q ? $signed(rdata[i*CW +: CW]) : '0;
				end
			end
			S_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					ve_q[i]  <= DW'(vb_q[i]) - DW'(va_q[i]);
					vw_q[i]  <= DW'(vc_q[i]) - DW'(va_q[i]);
					sum_q[i] <= SW'(va_q[i]) + SW'(vb_q[i]) + SW'(vc_q[i]);
				end
			end
			S_XMUL: begin
				// Products arrive in the cycle after their operands; even ones open a component.
				if (cnt_q != 3'd0) begin
					if (cnt_q[0]) begin
						cr_q[2'((cnt_q - 3'd1) >> 1)] <= XW'(prod_q);
					end else begin
						cr_q[2'((cnt_q - 3'd1) >> 1)] <=
							cr_q[2'((cnt_q - 3'd1) >> 1)] - XW'(prod_q);
					end
				end
			end
			S_MAG: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= cr_q[i][XW-1];
					mag_q[i] <= cr_q[i][XW-1] ? XW'(-cr_q[i]) : XW'(cr_q[i]);
					nrm_q[i] <= '0;
				end
				dist_q  <= '0;
				degen_q <= (cr_q[0] == '0 && cr_q[1] == '0 && cr_q[2] == '0);
				sumsq_q <= '0;
				dot_q   <= '0;
			end
			S_NORM: begin
				// Bring the largest magnitude into [2^30, 2^31) one bit a cycle.
				for (int i = 0; i < 3; i++) begin
					if (|mag_or[XW-1:31]) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (!mag_or[30]) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			S_SQ: begin
				if (cnt_q != 3'd0) begin
					sumsq_q <= sumsq_q + prod_q[63:0];
				end
			end
			S_SQRT: begin
				if (sqrt_done) begin
					m_q <= sqrt_root;
				end
			end
			S_NDIV: begin
				if (div_done) begin
					nrm_q[idx_q] <= neg_q[idx_q] ? -$signed(div_quo) : $signed(div_quo);
				end
			end
			S_DOT: begin
				if (cnt_q != 3'd0) begin
					dot_q <= dot_q + DAW'(prod_q);
				end
			end
			S_DCHK: begin
				// Without saturation the rounded magnitude fits in 34 bits.
				if (dsat) begin
					dist_q <= dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end else begin
					dm_q <= dm[33:0];
				end
			end
			S_DDIV: begin
				if (cnt_q == 3'd0) begin
					q3_q <= dm_q * RECIP3;
				end else if (dneg) begin
					dist_q <= (quo3 > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(quo3);
				end else begin
					dist_q <= (quo3 > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo3);
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_nx_q    <= nrm_q[0];
			out_ny_q    <= nrm_q[1];
			out_nz_q    <= nrm_q[2];
			out_dist_q  <= dist_q;
			out_degen_q <= degen_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.normal_x       = out_nx_q;
	assign result.normal_y       = out_ny_q;
	assign result.normal_z       = out_nz_q;
	assign result.plane_distance = out_dist_q;
	assign result.degenerate     = out_degen_q;
endmodule

>>> tb/tb_tpv_checker.sv
// ----------------------------------------------------------------------------
// tb_tpv_checker
// Watches the item and result channels, mirrors the vertex store, predicts
// the plane of every accepted compute word and compares each result word.
// ----------------------------------------------------------------------------
module tb_tpv_checker (
	input logic clk,
	input logic arst_n,
	tpv_item_if item,
	tpv_result_if result,
	output int fail_count,
	output int pending
);
	import tpv_pkg::*;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [DIST_W-1:0] pdist;
		logic                     degen;
	} plane_t;

	logic signed [63:0] vtx_x [VERTEX_DEPTH_DEF];
	logic signed [63:0] vtx_y [VERTEX_DEPTH_DEF];
	logic signed [63:0] vtx_z [VERTEX_DEPTH_DEF];
	plane_t planes_due [$];

	// Works out the plane of the triangle held in three store slots.
	function automatic plane_t triangle_plane(input logic [SLOT_W-1:0] sa,
		input logic [SLOT_W-1:0] sb, input logic [SLOT_W-1:0] sc);
		logic signed [63:0] ax, ay, az, ux, uy, uz, wx, wy, wz;
		logic signed [127:0] cr [3];
		logic [127:0] mg [3];
		logic [127:0] dm;
		logic signed [127:0] dot;
		logic [63:0] u [3];
		logic [63:0] sumsq, root, q, rem;
		logic signed [63:0] nv [3];
		int maxlen, k, j;
		plane_t p;
		ax = vtx_x[sa]; ay = vtx_y[sa]; az = vtx_z[sa];
		ux = vtx_x[sb] - ax; uy = vtx_y[sb] - ay; uz = vtx_z[sb] - az;
		wx = vtx_x[sc] - ax; wy = vtx_y[sc] - ay; wz = vtx_z[sc] - az;
		cr[0] = 128'(uy) * 128'(wz) - 128'(uz) * 128'(wy);
		cr[1] = 128'(uz) * 128'(wx) - 128'(ux) * 128'(wz);
		cr[2] = 128'(ux) * 128'(wy) - 128'(uy) * 128'(wx);
		maxlen = 0;
		for (k = 0; k < 3; k++) begin
			mg[k] = cr[k] < 0 ? -cr[k] : cr[k];
			for (j = 127; j >= 0; j--)
				if (mg[k][j] && j + 1 > maxlen) begin
					maxlen = j + 1;
					break;
				end
		end
		p = '0;
		if (maxlen == 0) begin
			p.degen = 1'b1;
			return p;
		end
		sumsq = 0;
		for (k = 0; k < 3; k++) begin
			u[k] = maxlen > 31 ? 64'(mg[k] >> (maxlen - 31)) : 64'(mg[k] << (31 - maxlen));
			sumsq += u[k] * u[k];
		end
		// Bitwise integer square root.
		root = 0;
		for (j = 31; j >= 0; j--)
			if ((root | (64'd1 << j)) * (root | (64'd1 << j)) <= sumsq)
				root |= 64'd1 << j;
		for (k = 0; k < 3; k++) begin
			q = ((u[k] << 30) + (root >> 1)) / root;
			nv[k] = cr[k] < 0 ? -$signed(q) : $signed(q);
		end
		p.nx = nv[0][31:0]; p.ny = nv[1][31:0]; p.nz = nv[2][31:0];
		dot = 128'(nv[0]) * 128'(ax + vtx_x[sb] + vtx_x[sc])
			+ 128'(nv[1]) * 128'(ay + vtx_y[sb] + vtx_y[sc])
			+ 128'(nv[2]) * 128'(az + vtx_z[sb] + vtx_z[sc]);
		dm = dot < 0 ? -dot : dot;
		dm = (dm + (128'd3 << 29)) >> 30;
		dm = dm / 3;
		if (dot < 0)
			rem = dm > 128'h8000_0000 ? 64'h8000_0000 : 64'(dm);
		else
			rem = dm > 128'h7FFF_FFFF ? 64'h7FFF_FFFF : 64'(dm);
		p.pdist = dot < 0 ? 32'(-rem) : 32'(rem);
		return p;
	endfunction

	assign pending = planes_due.size();

	// Mirror stores and expected planes; compare each result word.
	always @(posedge clk or negedge arst_n) begin
		plane_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
			planes_due.delete();
		end else begin
			if (item.valid && item.ready) begin
				if (item.mode == MODE_LOAD) begin
					vtx_x[item.vertex_slot] = 64'(item.coord_x);
					vtx_y[item.vertex_slot] = 64'(item.coord_y);
					vtx_z[item.vertex_slot] = 64'(item.coord_z);
				end else begin
					planes_due = {planes_due, triangle_plane(item.corner_a,
						item.corner_b, item.corner_c)};
				end
			end
			if (result.valid && result.ready) begin
				got = {result.normal_x, result.normal_y, result.normal_z,
					result.plane_distance, result.degenerate};
				if (planes_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result word %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = planes_due.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"mismatch: want n=(%0d,%0d,%0d) d=%0d g=%0b",
								" got n=(%0d,%0d,%0d) d=%0d g=%0b"},
								want.nx, want.ny, want.nz, want.pdist, want.degen,
								got.nx, got.ny, got.nz, got.pdist, got.degen);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives vertex loads and triangle compute words into the plane unit with
// random idling on both channels; the checker judges every result word.
// ----------------------------------------------------------------------------
module tb_top;
	import tpv_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int send_idle, recv_idle;
	logic written [VERTEX_DEPTH_DEF];
	int used_slots [$];

	tpv_item_if item ();
	tpv_result_if result ();

	triangle_plane_from_vertices DUT (.clk(clk), .arst_n(arst_n), .item(item),
		.result(result));
	tb_tpv_checker u_checker (.clk(clk), .arst_n(arst_n), .item(item),
		.result(result), .fail_count(fail_count), .pending(pending));

	always #6 clk = ~clk;

	// Receiver stalls at random.
	always @(posedge clk)
		result.ready <= arst_n && ($urandom_range(99) >= recv_idle);

	// Sends one word, with a random gap before it, and waits for acceptance.
	task automatic send_word(input logic md, input logic [SLOT_W-1:0] slot,
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z, input logic [SLOT_W-1:0] ca,
		input logic [SLOT_W-1:0] cb, input logic [SLOT_W-1:0] cc);
		while ($urandom_range(99) < send_idle) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1; item.mode <= md; item.vertex_slot <= slot;
		item.coord_x <= x; item.coord_y <= y; item.coord_z <= z;
		item.corner_a <= ca; item.corner_b <= cb; item.corner_c <= cc;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		if (md == MODE_LOAD && !written[slot]) begin
			written[slot] = 1'b1;
			used_slots = {used_slots, int'(slot)};
		end
	endtask

	task automatic load_vertex(input logic [SLOT_W-1:0] slot, input logic signed [31:0] x,
		input logic signed [31:0] y, input logic signed [31:0] z);
		send_word(MODE_LOAD, slot, x, y, z, SLOT_W'($urandom), SLOT_W'($urandom),
			SLOT_W'($urandom));
	endtask

	task automatic compute_plane(input logic [SLOT_W-1:0] ca,
		input logic [SLOT_W-1:0] cb, input logic [SLOT_W-1:0] cc);
		send_word(MODE_COMPUTE, SLOT_W'($urandom), $urandom, $urandom, $urandom,
			ca, cb, cc);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed(32'($urandom_range(65535 * 8))) - 32'sd262144;
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] pick_written();
		return SLOT_W'(used_slots[$urandom_range(used_slots.size() - 1)]);
	endfunction

	initial begin
		int k, phase;
		logic [SLOT_W-1:0] s0, s1, s2;
		item.valid = 1'b0; item.mode = MODE_LOAD; item.vertex_slot = '0;
		item.coord_x = '0; item.coord_y = '0; item.coord_z = '0;
		item.corner_a = '0; item.corner_b = '0; item.corner_c = '0;
		send_idle = 36; recv_idle = 66;
		foreach (written[i]) written[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, degenerate and saturating triangles.
		load_vertex(12'd0, 0, 0, 0);
		load_vertex(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		load_vertex(12'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		load_vertex(12'd2, 32'sh0001_0000, 0, 0);
		load_vertex(12'd3, 0, 32'sh0001_0000, 0);
		load_vertex(12'd4, 32'sh0002_0000, 0, 0);
		load_vertex(12'd5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
		load_vertex(12'd6, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		load_vertex(12'd7, 32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA);
		compute_plane(12'd0, 12'd2, 12'd3);
		compute_plane(12'd0, 12'd0, 12'd0);
		compute_plane(12'd0, 12'd2, 12'd4);
		compute_plane(12'd4095, 12'd1, 12'd5);
		compute_plane(12'd5, 12'd6, 12'd7);
		compute_plane(12'd3, 12'd2, 12'd0);
		compute_plane(12'd1, 12'd5, 12'd6);
		compute_plane(12'd7, 12'd4095, 12'd2);
		compute_plane(12'd4095, 12'd4095, 12'd1);

		// Random: mostly computes over loaded slots, some fresh loads.
		for (phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 36 : phase == 1 ? 66 : 0;
			recv_idle = phase == 0 ? 66 : phase == 1 ? 36 : 0;
			for (k = 0; k < 260; k++) begin
				if ($urandom_range(99) < 40) begin
					load_vertex(SLOT_W'($urandom), rand_coord(), rand_coord(),
						rand_coord());
				end else begin
					s0 = pick_written(); s1 = pick_written(); s2 = pick_written();
					compute_plane(s0, s1, $urandom_range(9) == 0 ? s0 : s2);
				end
			end
		end
		item.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Run limit: reports a failure and ends the run if the roughly 480 computes
	// have not finished before the limit is reached.
	initial begin
		#(12 * 2000000);
		$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> files.f
rtl/tpv_pkg.sv
rtl/tpv_item_if.sv
rtl/tpv_result_if.sv
rtl/tpv_ram.sv
rtl/tpv_div.sv
rtl/tpv_sqrt.sv
rtl/triangle_plane_from_vertices.sv
tb/tb_tpv_checker.sv
tb/tb_top.sv
